// ----- sv/stable_record_sorter_by_price_assert.svh -----
// Assertion macros for the stable record sorter.
`ifndef STABLE_RECORD_SORTER_BY_PRICE_ASSERT_SVH
`define STABLE_RECORD_SORTER_BY_PRICE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define SRTP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorter check failed");

// Next-cycle implication.
`define SRTP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorter check failed");

`endif

// ----- sv/srtp_pkg.sv -----
// Types and codes shared by the sorter cells and the top level.
package srtp_pkg;

   localparam int PRICE_W = 32;
   localparam int TAG_W   = 16;
   localparam int REM_W   = 10;

   // request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_TAKE   = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;
   localparam logic [1:0] REQ_NONE   = 2'd3;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [TAG_W-1:0]   tag;
   } entry_type;

   // broadcast to every cell
   typedef struct packed {
      logic      ins;
      logic      take;
      logic      clr;
      entry_type item;
   } cell_ctrl_type;

endpackage

// ----- sv/srtp_cell.sv -----
// One sorter cell: holds one entry and shifts with its neighbours.
module srtp_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  srtp_pkg::cell_ctrl_type ctrl,
   input  logic                  left_le,
   input  logic                  left_valid,
   input  srtp_pkg::entry_type   left_entry,
   input  logic                  right_valid,
   input  srtp_pkg::entry_type   right_entry,
   output logic                  le_out,
   output logic                  valid_out,
   output srtp_pkg::entry_type   entry_out
);
   import srtp_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      le;

   // entry stays put when it sorts at or before the new item
   assign le = valid_ff && (entry_ff.price <= ctrl.item.price);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      priority if (ctrl.clr) begin
         valid_in = 1'b0;
      end else if (ctrl.take) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end else if (ctrl.ins) begin
         if (!le) begin
            entry_in = left_le ? ctrl.item : left_entry;
         end
         valid_in = valid_ff | left_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign le_out    = le;
   assign valid_out = valid_ff;
   assign entry_out = entry_ff;

endmodule

// ----- sv/stable_record_sorter_by_price.sv -----
// Top level of the stable ascending record sorter: cell chain and result register.
//
//  channel | dir | transfer when          | payload
//  req     | in  | req_valid & req_ready  | req_type, req_price, req_tag, req_active
//  rsp     | out | rsp_valid & rsp_ready  | rsp_out_price, rsp_out_tag, rsp_found,
//          |     |                        | rsp_overflowed, rsp_remaining
//
// Each request is registered as it transfers; one may be taken each cycle
// while the result register is empty or being drained. The cell chain updates
// all CAPACITY cells together.
// Reset empties the chain and clears the sticky overflow flag at once.
// A take whose result has not been collected holds off further requests.
module stable_record_sorter_by_price #(
   parameter int CAPACITY = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [srtp_pkg::PRICE_W-1:0]  req_price,
   input  logic [srtp_pkg::TAG_W-1:0]    req_tag,
   input  logic                          req_active,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [srtp_pkg::PRICE_W-1:0]  rsp_out_price,
   output logic [srtp_pkg::TAG_W-1:0]    rsp_out_tag,
   output logic                          rsp_found,
   output logic                          rsp_overflowed,
   output logic [srtp_pkg::REM_W-1:0]    rsp_remaining
);
   import srtp_pkg::*;

   `include "stable_record_sorter_by_price_assert.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // occupancy and sticky flag
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   entry_type        rsp_entry_ff, rsp_entry_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [REM_W-1:0] rsp_rem_ff, rsp_rem_in;

   logic          xfer;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;

   // chain wiring
   logic      le_w    [CAPACITY];
   logic      valid_w [CAPACITY];
   entry_type entry_w [CAPACITY];

   // A request moves whenever the result register is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign xfer      = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   // broadcast to the cells; a full store drops inserts
   always_comb begin
      ctrl.ins        = xfer && (req_type == REQ_INSERT) && req_active && !full;
      ctrl.take       = xfer && (req_type == REQ_TAKE) && !empty;
      ctrl.clr        = xfer && (req_type == REQ_CLEAR);
      ctrl.item.price = req_price;
      ctrl.item.tag   = req_tag;
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_found_in = rsp_found_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (xfer) begin
         unique case (req_type)
            REQ_INSERT: begin
               if (req_active) begin
                  if (full) begin
                     ovf_in = 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            REQ_TAKE: begin
               rsp_valid_in = 1'b1;
               rsp_found_in = !empty;
               if (empty) begin
                  rsp_entry_in = '0;
                  rsp_rem_in   = '0;
               end else begin
                  // head cell always holds the lowest entry
                  rsp_entry_in = entry_w[0];
                  count_in     = count_ff - 1'b1;
                  rsp_rem_in   = REM_W'(count_in);
               end
            end
            REQ_CLEAR: count_in = '0;
            REQ_NONE:  ;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // overflow flag is sampled with the result, matching the take it answers
   logic rsp_ovf_ff, rsp_ovf_in;
   assign rsp_ovf_in = (xfer && (req_type == REQ_TAKE)) ? ovf_ff : rsp_ovf_ff;

   always_ff @(posedge clock) begin
      rsp_entry_ff <= rsp_entry_in;
      rsp_found_ff <= rsp_found_in;
      rsp_rem_ff   <= rsp_rem_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // Cell chain. Cell 0 sees a virtual left neighbour that is valid and
   // sorts before everything; the last cell sees an empty right neighbour.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      l_le, l_valid, r_valid;
      entry_type l_entry, r_entry;
      if (i == 0) begin : g_first
         assign l_le    = 1'b1;
         assign l_valid = 1'b1;
         assign l_entry = ctrl.item;
      end else begin : g_mid
         assign l_le    = le_w[i-1];
         assign l_valid = valid_w[i-1];
         assign l_entry = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign r_valid = 1'b0;
         assign r_entry = entry_w[i];
      end else begin : g_inner
         assign r_valid = valid_w[i+1];
         assign r_entry = entry_w[i+1];
      end
      srtp_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_le     (l_le),
         .left_valid  (l_valid),
         .left_entry  (l_entry),
         .right_valid (r_valid),
         .right_entry (r_entry),
         .le_out      (le_w[i]),
         .valid_out   (valid_w[i]),
         .entry_out   (entry_w[i])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_price  = rsp_entry_ff.price;
   assign rsp_out_tag    = rsp_entry_ff.tag;
   assign rsp_found      = rsp_found_ff;
   assign rsp_overflowed = rsp_ovf_ff;
   assign rsp_remaining  = rsp_rem_ff;

   // occupancy counter agrees with the valid prefix at both ends of the chain
   `SRTP_ASSERT_NOW(a_head_valid, 1'b1, valid_w[0] == !empty)
   `SRTP_ASSERT_NOW(a_tail_valid, 1'b1, valid_w[CAPACITY-1] == full)
   `SRTP_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `SRTP_ASSERT_NEXT(a_take_count, ctrl.take, count_ff == $past(count_ff) - 1'b1)

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the stable record sorter: a queue-based price book predicts every take.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import srtp_pkg::*;

   // Store depth; the predictor and the instance must agree on it.
   localparam int BOOK_DEPTH  = 512;
   // Cycles without any transfer before the run is declared hung.
   localparam int HANG_LIMIT  = 2000;
   // Settling time after the last result.
   localparam int TAIL_CYCLES = 10;

   // One expected take result, laid out as the rsp_ ports.
   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [TAG_W-1:0]   tag;
      logic               found;
      logic               overflowed;
      logic [REM_W-1:0]   remaining;
   } take_result_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_type = REQ_NONE;
   logic [PRICE_W-1:0] req_price = '0;
   logic [TAG_W-1:0]   req_tag = '0;
   logic               req_active = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [PRICE_W-1:0] rsp_out_price;
   logic [TAG_W-1:0]   rsp_out_tag;
   logic               rsp_found;
   logic               rsp_overflowed;
   logic [REM_W-1:0]   rsp_remaining;

   // Predictor state: the book in ascending price order, arrival order among
   // equal prices, plus the sticky full-store flag.
   entry_type       price_book[$];
   logic            book_overflow = 1'b0;
   take_result_type awaited_takes[$];

   // Idle odds in percent for each side, changed per phase.
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;

   int quiet_cycles   = 0;
   int n_requests     = 0;
   int n_inserts      = 0;
   int n_takes        = 0;
   int n_empty_takes  = 0;
   int n_dropped_full = 0;
   int n_checked      = 0;
   int n_errors       = 0;
   int deepest        = 0;

   stable_record_sorter_by_price #(
      .CAPACITY(BOOK_DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_price      (req_price),
      .req_tag        (req_tag),
      .req_active     (req_active),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_price  (rsp_out_price),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_found      (rsp_found),
      .rsp_overflowed (rsp_overflowed),
      .rsp_remaining  (rsp_remaining)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: applies one accepted request to the book and, for a take,
   // queues the result the block must return.
   // ---------------------------------------------------------------------
   function automatic void book_update(input logic [1:0] kind,
                                       input logic [PRICE_W-1:0] price,
                                       input logic [TAG_W-1:0] tag,
                                       input logic active);
      int              slot;
      entry_type       rec;
      take_result_type res;
      case (kind)
         REQ_INSERT: begin
            if (active) begin
               n_inserts++;
               if (price_book.size() >= BOOK_DEPTH) begin
                  // full store: record lost, flag sticks until reset
                  book_overflow = 1'b1;
                  n_dropped_full++;
               end else begin
                  // goes after every entry of lower or equal price
                  slot = 0;
                  while (slot < price_book.size() && price_book[slot].price <= price)
                     slot++;
                  rec.price = price;
                  rec.tag   = tag;
                  price_book.insert(slot, rec);
                  if (price_book.size() > deepest)
                     deepest = price_book.size();
               end
            end
         end
         REQ_TAKE: begin
            n_takes++;
            res = '0;
            res.overflowed = book_overflow;
            if (price_book.size() == 0) begin
               n_empty_takes++;
            end else begin
               rec           = price_book.pop_front();
               res.price     = rec.price;
               res.tag       = rec.tag;
               res.found     = 1'b1;
               res.remaining = REM_W'(price_book.size());
            end
            awaited_takes.push_back(res);
         end
         REQ_CLEAR: begin
            price_book.delete();
         end
         default: begin
            // unknown request: no effect at all
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Valid goes up with the payload at a clock edge and stays
   // until the transfer; it is only lowered for an idle gap or a pause.
   // ---------------------------------------------------------------------
   task automatic send_req(input logic [1:0] kind,
                           input logic [PRICE_W-1:0] price,
                           input logic [TAG_W-1:0] tag,
                           input logic active);
      while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_type   <= kind;
      req_price  <= price;
      req_tag    <= tag;
      req_active <= active;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      // transfer at this edge
      n_requests++;
      book_update(kind, price, tag, active);
   endtask

   // Holds requests off until every awaited take has come back.
   task automatic drain_takes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_takes.size() != 0)
         @(posedge clock);
   endtask

   // Price mix: a small set of values for many ties, the two ends, and full range.
   function automatic logic [PRICE_W-1:0] pick_price();
      case ($urandom_range(9))
         0, 1, 2, 3: pick_price = PRICE_W'($urandom_range(7));
         4:          pick_price = '0;
         5:          pick_price = '1;
         6:          pick_price = 32'hFFFF_FFF8 + PRICE_W'($urandom_range(7));
         default:    pick_price = $urandom;
      endcase
   endfunction

   function automatic logic [TAG_W-1:0] pick_tag();
      pick_tag = TAG_W'($urandom_range(16'hFFFF));
   endfunction

   // ---------------------------------------------------------------------
   // Result side: checks each transfer against the oldest awaited take,
   // drives the receiver stalls and keeps the hang watchdog.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      n_errors++;
   endtask

   always @(posedge clock) begin : rsp_check
      take_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (awaited_takes.size() == 0) begin
            $display("%0t: result with none awaited, got price %0h tag %0h found %0b",
                     $time, rsp_out_price, rsp_out_tag, rsp_found);
            n_errors++;
         end else begin
            want = awaited_takes.pop_front();
            n_checked++;
            if (rsp_out_price !== want.price)
               report_mismatch("out_price", want.price, rsp_out_price);
            if (rsp_out_tag !== want.tag)
               report_mismatch("out_tag", 32'(want.tag), 32'(rsp_out_tag));
            if (rsp_found !== want.found)
               report_mismatch("found", 32'(want.found), 32'(rsp_found));
            if (rsp_overflowed !== want.overflowed)
               report_mismatch("overflowed", 32'(want.overflowed), 32'(rsp_overflowed));
            if (rsp_remaining !== want.remaining)
               report_mismatch("remaining", 32'(want.remaining), 32'(rsp_remaining));
         end
      end
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      rsp_ready <= (rcv_idle_pct == 0) || ($urandom_range(99) >= rcv_idle_pct);
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d takes still awaited",
                  $time, quiet_cycles, awaited_takes.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Short hand-made sequence: empty takes, inactive and unknown requests,
   // both price ends, ties kept in arrival order, and clear.
   task automatic test_directed();
      send_req(REQ_TAKE,   '0, '0, 1'b0);              // empty store
      send_req(REQ_INSERT, 32'd5, 16'd1, 1'b0);        // inactive, dropped
      send_req(REQ_TAKE,   '1, '1, 1'b1);              // still empty
      send_req(REQ_INSERT, '1, '1, 1'b1);              // top price, top tag
      send_req(REQ_INSERT, '0, '0, 1'b1);              // bottom price
      send_req(REQ_INSERT, 32'd100, 16'd10, 1'b1);
      send_req(REQ_INSERT, 32'd100, 16'd11, 1'b1);     // tie, must follow tag 10
      send_req(REQ_INSERT, 32'd100, 16'd12, 1'b1);
      send_req(REQ_INSERT, 32'd50, 16'd13, 1'b1);      // lands ahead of the ties
      send_req(REQ_NONE,   '0, '0, 1'b1);              // ignored, no insert
      send_req(REQ_TAKE,   '0, '0, 1'b0);              // 0
      send_req(REQ_TAKE,   '0, '0, 1'b0);              // 50
      send_req(REQ_TAKE,   '0, '0, 1'b0);              // 100 / 10
      send_req(REQ_INSERT, 32'd100, 16'd14, 1'b0);     // inactive tie
      send_req(REQ_TAKE,   '0, '0, 1'b0);              // 100 / 11
      send_req(REQ_INSERT, 32'd100, 16'hAAAA, 1'b1);   // tie behind tag 12
      send_req(REQ_TAKE,   '0, '0, 1'b0);              // 100 / 12
      send_req(REQ_TAKE,   '0, '0, 1'b0);              // 100 / AAAA
      send_req(REQ_TAKE,   '0, '0, 1'b0);              // top price, store now empty
      send_req(REQ_TAKE,   '0, '0, 1'b0);              // empty again
      send_req(REQ_INSERT, 32'd7, 16'h5555, 1'b1);
      send_req(REQ_INSERT, 32'd3, 16'h1234, 1'b1);
      send_req(REQ_CLEAR,  '1, '1, 1'b1);
      send_req(REQ_TAKE,   '0, '0, 1'b0);              // empty after clear
      send_req(REQ_NONE,   $urandom, pick_tag(), 1'b0);
   endtask

   // Random traffic, weighted towards inserts so the book grows between clears.
   task automatic test_random_mix(input int count);
      int          pick;
      logic [1:0]  kind;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 55)      kind = REQ_INSERT;
         else if (pick < 95) kind = REQ_TAKE;
         else if (pick < 97) kind = REQ_CLEAR;
         else                kind = REQ_NONE;
         send_req(kind, pick_price(), pick_tag(), $urandom_range(9) != 0);
      end
   endtask

   // Sender stops and waits for every result before carrying on.
   task automatic test_pause_until_drained();
      drain_takes();
      send_req(REQ_TAKE, '0, '0, 1'b0);
   endtask

   // Fill the store to capacity, then push past it to raise the sticky flag.
   task automatic test_fill_overflow();
      send_req(REQ_CLEAR, '0, '0, 1'b0);
      for (int i = 0; i < BOOK_DEPTH; i++)
         send_req(REQ_INSERT, pick_price(), TAG_W'(i), 1'b1);
      send_req(REQ_INSERT, '0, '1, 1'b0);      // inactive on a full store: no flag
      send_req(REQ_TAKE, '0, '0, 1'b0);        // 511 left, flag still low
      send_req(REQ_INSERT, 32'd4, 16'hBEEF, 1'b1);
      send_req(REQ_INSERT, 32'd2, 16'hDEAD, 1'b1);   // full: dropped
      send_req(REQ_INSERT, '0, 16'hCAFE, 1'b1);      // full: dropped
      for (int i = 0; i < 20; i++)
         send_req(REQ_TAKE, '0, '0, 1'b0);
      send_req(REQ_CLEAR, '0, '0, 1'b0);
      send_req(REQ_TAKE, '0, '0, 1'b0);        // empty, flag survives clear
   endtask

   // ---------------------------------------------------------------------
   // Sequence of phases
   // ---------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles rarely, receiver often
      snd_idle_pct = 11;
      rcv_idle_pct = 56;
      test_directed();
      test_random_mix(400);

      // the other way round
      snd_idle_pct = 56;
      rcv_idle_pct = 11;
      test_random_mix(200);
      test_pause_until_drained();
      test_random_mix(200);

      // back to back on both sides
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      test_fill_overflow();
      test_random_mix(200);

      drain_takes();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_takes.size() != 0) begin
         $display("%0t: %0d takes never answered", $time, awaited_takes.size());
         n_errors++;
      end

      $display("Covered %0d requests: %0d active inserts (%0d lost on a full store), %0d takes",
               n_requests, n_inserts, n_dropped_full, n_takes);
      $display("%0d takes on an empty store, book depth up to %0d, %0d results checked",
               n_empty_takes, deepest, n_checked);
      if (n_errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
